// ===== rtl/core/slt_pkg.sv =====
// Package for the sorted list table: command and status codes, and the
// structs passed between the top level and the row of storage cells.
// No dependencies.
package slt_pkg;

    // Widest entry the cells support; the command bus carries this many bits
    localparam int unsigned VAL_BUS_W = 64;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_REWIND = 3'd4,
        CMD_NEXT   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ITER_END  = 2'd3
    } t_status;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic                 ins_en;
        logic                 del_en;
        logic [VAL_BUS_W-1:0] value;
    } t_cell_cmd;

    // Compare results of one cell against the broadcast value
    typedef struct packed {
        logic le;
        logic lt;
        logic match;
    } t_cell_flags;

endpackage

// ===== rtl/core/slt_if.sv =====
// Valid/ready channel interfaces for the sorted list table: the command
// channel and the result channel. Depends on nothing.
interface slt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface slt_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] item_out;
    logic [5:0]  count;
    logic        full_res;
    logic [1:0]  status;

    modport source (output valid, output found, output item_out, output count,
                    output full_res, output status, input ready);
    modport sink   (input valid, input found, input item_out, input count,
                    input full_res, input status, output ready);
endinterface

// ===== rtl/core/slt_cell.sv =====
// One storage cell of the sorted list table: holds one entry, compares it
// with the broadcast value and shifts towards either neighbour. Uses slt_pkg.
module slt_cell #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  slt_pkg::t_cell_cmd      i_cmd,
    input  logic                    i_active,
    input  logic                    i_sel,
    input  logic [VALUE_WIDTH-1:0]  i_left_val,
    input  logic                    i_left_le,
    input  logic [VALUE_WIDTH-1:0]  i_right_val,
    output logic [VALUE_WIDTH-1:0]  o_val,
    output slt_pkg::t_cell_flags    o_flags,
    output logic [VALUE_WIDTH-1:0]  o_rd
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic [VALUE_WIDTH-1:0] w_key;

    assign w_key = i_cmd.value[VALUE_WIDTH-1:0];

    assign o_flags.le    = i_active && (r_val <= w_key);
    assign o_flags.lt    = i_active && (r_val <  w_key);
    assign o_flags.match = i_active && (r_val == w_key);

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins_en) begin
            // keep if at or below the key, take the key at the boundary, else shift up
            if (!o_flags.le) begin
                n_val = i_left_le ? w_key : i_left_val;
            end
        end else if (i_cmd.del_en) begin
            // everything from the first equal entry onwards shifts down
            if (!o_flags.lt) begin
                n_val = i_right_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = i_sel ? r_val : '0;

endmodule

// ===== rtl/core/sorted_list_table.sv =====
// Sorted list table: keeps up to CAPACITY unsigned values in ascending order in a row of
// compare-and-shift cells. Insert, delete, query, clear, rewind and next each take one
// beat: every cell compares against the command value in parallel and shifts from its
// neighbour, so a command is accepted every cycle while the result channel does not
// stall, and its result beat appears in the next cycle from the output register. The
// result register accepts a new command while its beat is being taken. Depends on slt_pkg,
// slt_if and slt_cell.
module sorted_list_table #(
    parameter int unsigned CAPACITY    = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slt_cmd_if.sink    i_cmd_ch,
    slt_res_if.source  o_res_ch
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_iter;
    logic [CNT_W-1:0] n_iter;

    logic                 r_out_valid;
    logic                 r_found;
    logic [31:0]          r_item;
    logic [5:0]           r_count_out;
    logic                 r_full;
    slt_pkg::t_status     r_status;

    logic                 w_in_acc;
    logic                 w_ins;
    logic                 w_del;
    logic                 w_found_any;
    logic                 res_found;
    logic [VALUE_WIDTH-1:0] res_item;
    slt_pkg::t_status     res_status;
    logic [VALUE_WIDTH-1:0] w_rd_or;
    logic [63:0]          w_item_ext;
    logic [15:0]          w_count_ext;
    logic [63:0]          w_value_bus;
    slt_pkg::t_cell_cmd   w_cell_cmd;

    logic [VALUE_WIDTH-1:0] w_val   [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_rd    [CAPACITY];
    slt_pkg::t_cell_flags   w_flags [CAPACITY];
    logic [CAPACITY-1:0]    w_match;

    assign i_cmd_ch.ready = !r_out_valid || o_res_ch.ready;
    assign w_in_acc       = i_cmd_ch.valid && i_cmd_ch.ready;

    assign w_value_bus       = {32'b0, i_cmd_ch.value};
    assign w_cell_cmd.ins_en = w_ins && w_in_acc;
    assign w_cell_cmd.del_en = w_del && w_in_acc;
    assign w_cell_cmd.value  = w_value_bus;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left_val;
        logic                   w_left_le;
        logic [VALUE_WIDTH-1:0] w_right_val;

        if (g == 0) begin : g_first
            assign w_left_val = '0;
            assign w_left_le  = 1'b1;
        end else begin : g_mid
            assign w_left_val = w_val[g-1];
            assign w_left_le  = w_flags[g-1].le;
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        slt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cell_cmd),
            .i_active    (CNT_W'(g) < r_count),
            .i_sel       (r_iter == CNT_W'(g)),
            .i_left_val  (w_left_val),
            .i_left_le   (w_left_le),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_flags     (w_flags[g]),
            .o_rd        (w_rd[g])
        );

        assign w_match[g] = w_flags[g].match;
    end

    assign w_found_any = |w_match;

    // only the cell under the iterator drives a non-zero read word
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_or = w_rd_or | w_rd[i];
        end
    end

    always_comb begin
        n_count    = r_count;
        n_iter     = r_iter;
        res_found  = 1'b0;
        res_item   = '0;
        res_status = slt_pkg::ST_OK;
        w_ins      = 1'b0;
        w_del      = 1'b0;
        case (i_cmd_ch.cmd)
            slt_pkg::CMD_INSERT: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    res_status = slt_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            slt_pkg::CMD_DELETE: begin
                if (w_found_any) begin
                    res_found = 1'b1;
                    w_del     = 1'b1;
                    n_count   = r_count - 1'b1;
                end else begin
                    res_status = slt_pkg::ST_NOT_FOUND;
                end
            end
            slt_pkg::CMD_QUERY: begin
                res_found = w_found_any;
            end
            slt_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            slt_pkg::CMD_REWIND: begin
                n_iter = '0;
            end
            slt_pkg::CMD_NEXT: begin
                if (r_iter < r_count) begin
                    res_item = w_rd_or;
                    n_iter   = r_iter + 1'b1;
                end else begin
                    res_status = slt_pkg::ST_ITER_END;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_item_ext  = 64'(res_item);
    assign w_count_ext = 16'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_iter      <= n_iter;
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: hold until the next accepted command
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_found     <= res_found;
            r_item      <= w_item_ext[31:0];
            r_count_out <= w_count_ext[5:0];
            r_full      <= (n_count == CNT_W'(CAPACITY));
            r_status    <= res_status;
        end
    end

    assign o_res_ch.valid    = r_out_valid;
    assign o_res_ch.found    = r_found;
    assign o_res_ch.item_out = r_item;
    assign o_res_ch.count    = r_count_out;
    assign o_res_ch.full_res = r_full;
    assign o_res_ch.status   = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd_ch.cmd == slt_pkg::CMD_INSERT && r_count != CNT_W'(CAPACITY))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the table");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == slt_pkg::ST_FULL) |-> r_full)
        else $error("insert refused while table not full");

    a_iter_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == slt_pkg::ST_ITER_END) |-> (r_item == 32'd0))
        else $error("iterator end with non-zero item");

endmodule
